>>> rtl/fca_pkg.sv
// Package: types, constants and codes shared by the chain allocator.
`timescale 1ns / 1ps
package fca_pkg;
  localparam int NumBlocks = 4096;
  localparam int BlkW = $clog2(NumBlocks);
  localparam int EntW = 14;
  localparam int DoneW = BlkW + 1;

  typedef logic [EntW-1:0] ent_t;
  typedef logic [BlkW-1:0] blk_t;
  typedef logic [DoneW-1:0] done_t;

  localparam ent_t MarkFree = {EntW{1'b1}};
  localparam ent_t MarkEnd = {{(EntW-1){1'b1}}, 1'b0};
  localparam ent_t EntLimit = ent_t'(NumBlocks);
  localparam blk_t LastBlk = blk_t'(NumBlocks - 1);
  localparam done_t WalkLimit = done_t'(NumBlocks - 1);
  localparam logic [7:0] MaxChainReset = 8'd128;

  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree = 2'd1;
  localparam logic [1:0] OpTrunc = 2'd2;
  localparam logic [1:0] OpNext = 2'd3;

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StTooLarge = 3'd1;
  localparam logic [2:0] StNoSpace = 3'd2;
  localparam logic [2:0] StEnd = 3'd3;
  localparam logic [2:0] StFree = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [BlkW-1:0] chain_start;
    logic [7:0] block_count;
  } req_t;

  typedef struct packed {
    logic [BlkW-1:0] result_block;
    logic [DoneW-1:0] blocks_done;
    logic [2:0] status;
  } res_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_OUT,
    S_A_RD, S_A_CHK, S_A_LNK, S_A_NXT,
    S_H_RD, S_H_CHK, S_N_CHK,
    S_T_RD, S_T_CHK, S_T_CHK2, S_T_DEC,
    S_W_RD, S_W_CHK, S_C_CHK,
    S_F_RD, S_F_CHK, S_F_CHK2
  } state_t;
endpackage

>>> rtl/fca_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module fca_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/fat_chain_allocator_unit.sv
// Top level of the chain allocator: table sequencer, configuration port and result register.
// The allocation table sits in one single-port RAM of NUM_BLOCKS entries with a registered
// read. After reset a clearing pass marks every entry free, and no request is taken
// meanwhile. Allocate scans from block 0: it reads each entry, passes over occupied ones,
// marks each free block it takes as the end of the new chain and links the previous block
// to it; a rejected or zero-length allocate presents its result the cycle after it is
// taken. Free reads the start block, then for each block reads its follower and frees the
// block. Truncate reads the start block, measures the chain, decides, walks to the cut,
// marks the cut with an end mark and frees the tail as free does; a zero count frees the
// whole chain. Next reads the start block and, for an in-range link, the block it names.
// One request is processed at a time; the result waits in an output register and the next
// request may enter the cycle after it has been taken.
`timescale 1ns / 1ps
module fat_chain_allocator_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  fca_pkg::req_t     req_data,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output fca_pkg::res_t     rsp_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [7:0] max_chain;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, max_chain} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) max_chain <= fca_pkg::MaxChainReset;
    else if (psel && penable && pwrite && paddr == 2'd0) max_chain <= pwdata[7:0];
  end

  fca_pkg::state_t state, state_next;
  logic we;
  fca_pkg::blk_t addr;
  fca_pkg::ent_t wdata, rdata;

  fca_ram #(.Width(fca_pkg::EntW), .Depth(fca_pkg::NumBlocks)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Working registers.
  fca_pkg::req_t req;
  fca_pkg::blk_t cur, cur_next;     // block under consideration
  fca_pkg::blk_t prv, prv_next;     // previous block of the new chain
  fca_pkg::blk_t lnk, lnk_next;     // link read from cur; in allocate, the block to be linked
  fca_pkg::blk_t first, first_next;
  fca_pkg::done_t cnt, cnt_next;
  fca_pkg::done_t len, len_next;
  fca_pkg::done_t want;
  fca_pkg::res_t res, res_next;
  logic in_rng, is_free;
  fca_pkg::blk_t rd_blk;

  // A link is valid when it points inside the table; out-of-range codes are marks.
  assign in_rng = (rdata < fca_pkg::EntLimit);
  assign is_free = (rdata == fca_pkg::MarkFree);
  assign rd_blk = rdata[fca_pkg::BlkW-1:0];
  assign want = fca_pkg::done_t'(req.block_count);

  always_comb begin
    state_next = state;
    we = 1'b0;
    addr = cur;
    wdata = fca_pkg::MarkFree;
    cur_next = cur;
    prv_next = prv;
    lnk_next = lnk;
    first_next = first;
    cnt_next = cnt;
    len_next = len;
    res_next = res;
    req_stall = 1'b1;
    rsp_valid = 1'b0;
    unique case (state)
      fca_pkg::S_CLEAR: begin
        we = 1'b1;
        cur_next = cur + 1'b1;
        if (cur == fca_pkg::LastBlk) begin
          state_next = fca_pkg::S_IDLE;
          cur_next = '0;
        end
      end
      fca_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cur_next = req_data.chain_start;
          cnt_next = '0;
          len_next = '0;
          res_next = '0;
          first_next = '0;
          if (req_data.opcode == fca_pkg::OpAlloc) begin
            cur_next = '0;
            if (req_data.block_count > max_chain) begin
              res_next.status = fca_pkg::StTooLarge;
              state_next = fca_pkg::S_OUT;
            end else if (req_data.block_count == 8'd0) begin
              state_next = fca_pkg::S_OUT;
            end else begin
              state_next = fca_pkg::S_A_RD;
            end
          end else begin
            state_next = fca_pkg::S_H_RD;
          end
        end
      end
      fca_pkg::S_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) state_next = fca_pkg::S_IDLE;
      end
      fca_pkg::S_A_RD: state_next = fca_pkg::S_A_CHK;
      fca_pkg::S_A_CHK: begin
        if (is_free) begin
          we = 1'b1;
          wdata = fca_pkg::MarkEnd;
          prv_next = cur;
          lnk_next = prv;
          cnt_next = cnt + 1'b1;
          if (cnt == '0) begin
            first_next = cur;
            state_next = fca_pkg::S_A_NXT;
          end else begin
            state_next = fca_pkg::S_A_LNK;
          end
        end else if (cur == fca_pkg::LastBlk) begin
          res_next.result_block = first;
          res_next.blocks_done = cnt;
          res_next.status = fca_pkg::StNoSpace;
          state_next = fca_pkg::S_OUT;
        end else begin
          // Occupied: read the following entry straight away.
          cur_next = cur + 1'b1;
          addr = cur + 1'b1;
        end
      end
      // Link the previous block of the new chain to the one just taken.
      fca_pkg::S_A_LNK: begin
        we = 1'b1;
        addr = lnk;
        wdata = fca_pkg::ent_t'(cur);
        state_next = fca_pkg::S_A_NXT;
      end
      fca_pkg::S_A_NXT: begin
        if (cnt == want) begin
          res_next.result_block = first;
          res_next.blocks_done = cnt;
          state_next = fca_pkg::S_OUT;
        end else if (cur == fca_pkg::LastBlk) begin
          res_next.result_block = first;
          res_next.blocks_done = cnt;
          res_next.status = fca_pkg::StNoSpace;
          state_next = fca_pkg::S_OUT;
        end else begin
          cur_next = cur + 1'b1;
          addr = cur + 1'b1;
          state_next = fca_pkg::S_A_CHK;
        end
      end
      fca_pkg::S_H_RD: state_next = fca_pkg::S_H_CHK;
      fca_pkg::S_H_CHK: begin
        if (is_free) begin
          res_next.status = fca_pkg::StFree;
          state_next = fca_pkg::S_OUT;
        end else if (req.opcode == fca_pkg::OpFree) begin
          state_next = fca_pkg::S_F_RD;
        end else if (req.opcode == fca_pkg::OpNext) begin
          if (in_rng) begin
            lnk_next = rd_blk;
            addr = rd_blk;
            state_next = fca_pkg::S_N_CHK;
          end else begin
            res_next.status = fca_pkg::StEnd;
            state_next = fca_pkg::S_OUT;
          end
        end else begin
          state_next = fca_pkg::S_T_RD;
        end
      end
      // Next: a link to a free block counts as the end of the chain.
      fca_pkg::S_N_CHK: begin
        if (is_free) res_next.status = fca_pkg::StEnd;
        else res_next.result_block = lnk;
        state_next = fca_pkg::S_OUT;
      end
      // Truncate pass one: measure the chain; len counts blocks visited.
      fca_pkg::S_T_RD: state_next = fca_pkg::S_T_CHK;
      fca_pkg::S_T_CHK: begin
        len_next = len + 1'b1;
        if (in_rng && len != fca_pkg::WalkLimit) begin
          lnk_next = rd_blk;
          addr = rd_blk;
          state_next = fca_pkg::S_T_CHK2;
        end else begin
          state_next = fca_pkg::S_T_DEC;
        end
      end
      fca_pkg::S_T_CHK2: begin
        if (is_free) begin
          state_next = fca_pkg::S_T_DEC;
        end else begin
          cur_next = lnk;
          addr = lnk;
          state_next = fca_pkg::S_T_CHK;
        end
      end
      fca_pkg::S_T_DEC: begin
        cur_next = req.chain_start;
        if (want > len) begin
          res_next.status = fca_pkg::StTooLarge;
          state_next = fca_pkg::S_OUT;
        end else if (want == '0) begin
          state_next = fca_pkg::S_F_RD;
        end else begin
          cnt_next = fca_pkg::done_t'(1);
          state_next = fca_pkg::S_W_RD;
        end
      end
      // Walk to the last kept block; the links were checked while measuring.
      fca_pkg::S_W_RD: state_next = fca_pkg::S_W_CHK;
      fca_pkg::S_W_CHK: begin
        if (cnt != want) begin
          cur_next = rd_blk;
          addr = rd_blk;
          cnt_next = cnt + 1'b1;
        end else if (in_rng) begin
          lnk_next = rd_blk;
          addr = rd_blk;
          state_next = fca_pkg::S_C_CHK;
        end else begin
          we = 1'b1;
          wdata = fca_pkg::MarkEnd;
          state_next = fca_pkg::S_OUT;
        end
      end
      // Cut point: mark the end, then free the tail unless its link was broken.
      fca_pkg::S_C_CHK: begin
        we = 1'b1;
        wdata = fca_pkg::MarkEnd;
        cnt_next = '0;
        if (is_free) begin
          state_next = fca_pkg::S_OUT;
        end else begin
          cur_next = lnk;
          state_next = fca_pkg::S_F_RD;
        end
      end
      // Free walk: read cur, check the follower, then free cur.
      fca_pkg::S_F_RD: state_next = fca_pkg::S_F_CHK;
      fca_pkg::S_F_CHK: begin
        if (in_rng) begin
          lnk_next = rd_blk;
          addr = rd_blk;
          state_next = fca_pkg::S_F_CHK2;
        end else begin
          we = 1'b1;
          cnt_next = cnt + 1'b1;
          res_next.blocks_done = cnt + 1'b1;
          state_next = fca_pkg::S_OUT;
        end
      end
      fca_pkg::S_F_CHK2: begin
        we = 1'b1;
        cnt_next = cnt + 1'b1;
        res_next.blocks_done = cnt + 1'b1;
        if (!is_free && cnt != fca_pkg::WalkLimit) begin
          cur_next = lnk;
          state_next = fca_pkg::S_F_RD;
        end else begin
          state_next = fca_pkg::S_OUT;
        end
      end
      default: state_next = fca_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fca_pkg::S_CLEAR;
      cur <= '0;
    end else begin
      state <= state_next;
      cur <= cur_next;
    end
    prv <= prv_next;
    lnk <= lnk_next;
    first <= first_next;
    cnt <= cnt_next;
    len <= len_next;
    res <= res_next;
    if (state == fca_pkg::S_IDLE && req_valid) req <= req_data;
  end

  assign rsp_data = res;

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall) else $error("request taken while a result waits");
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_data))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (rst)
    (state == fca_pkg::S_OUT && res.status == fca_pkg::StTooLarge) |-> res.blocks_done == '0)
    else $error("rejected request reports work done");
  assert property (@(posedge clk) disable iff (rst)
    (state == fca_pkg::S_CLEAR) |-> req_stall)
    else $error("request taken during the clearing pass");
endmodule
